[rtl/gdt_pkg.sv]
// Package for the gesture direction tracker: field widths, operation and
// direction codes, and the result record passed between the tracker modules.
// Has no dependencies.
package gdt_pkg;

    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned BUTTON_W = 10;
    localparam int unsigned DELTA_W  = 16;
    localparam int unsigned THRESH_W = 16;
    localparam int unsigned TICK_W   = 32;
    localparam int unsigned DIR_W    = 4;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd100;
    localparam logic [TICK_W-1:0]   TICK_MAX     = 32'hFFFF_FFFF;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK    = 3'd0,
        FN_START   = 3'd1,
        FN_STOP    = 3'd2,
        FN_MOTION  = 3'd3,
        FN_RESOLVE = 3'd4
    } gdt_func_t;

    typedef enum logic [DIR_W-1:0] {
        MOVE_NONE       = 4'd0,
        MOVE_UP         = 4'd1,
        MOVE_DOWN       = 4'd2,
        MOVE_LEFT       = 4'd3,
        MOVE_RIGHT      = 4'd4,
        MOVE_UP_LEFT    = 4'd5,
        MOVE_UP_RIGHT   = 4'd6,
        MOVE_DOWN_LEFT  = 4'd7,
        MOVE_DOWN_RIGHT = 4'd8
    } gdt_dir_t;

    typedef struct packed {
        logic [TICK_W-1:0]   elapsed;
        logic [BUTTON_W-1:0] held_button;
        logic                active;
        gdt_dir_t            direction;
    } gdt_result_t;

endpackage

[rtl/gdt_classify.sv]
// Direction classifier: turns the X and Y travel sums into one of eight
// directions, or none when the dominant travel is below the threshold.
// Depends on gdt_pkg.
module gdt_classify #(
    parameter int unsigned ACC_BITS = 24
) (
    input  logic signed [ACC_BITS-1:0]          sum_x,
    input  logic signed [ACC_BITS-1:0]          sum_y,
    input  logic        [gdt_pkg::THRESH_W-1:0] threshold,
    output gdt_pkg::gdt_dir_t                   direction
);

    logic [ACC_BITS-1:0] abs_x;
    logic [ACC_BITS-1:0] abs_y;
    logic [ACC_BITS-1:0] abs_max;
    logic [ACC_BITS-1:0] max_half;
    logic [ACC_BITS-1:0] thresh_ext;
    logic                x_pos;
    logic                y_pos;

    assign abs_x      = sum_x[ACC_BITS-1] ? (~sum_x + 1'b1) : sum_x;
    assign abs_y      = sum_y[ACC_BITS-1] ? (~sum_y + 1'b1) : sum_y;
    assign abs_max    = (abs_x > abs_y) ? abs_x : abs_y;
    assign max_half   = abs_max >> 1;
    assign thresh_ext = {{(ACC_BITS-gdt_pkg::THRESH_W){1'b0}}, threshold};
    assign x_pos      = !sum_x[ACC_BITS-1] && (sum_x != '0);
    assign y_pos      = !sum_y[ACC_BITS-1] && (sum_y != '0);

    always_comb begin
        if (abs_max < thresh_ext) begin
            direction = gdt_pkg::MOVE_NONE;
        end else if ((abs_x > max_half) && (abs_y > max_half)) begin
            if (x_pos) begin
                direction = y_pos ? gdt_pkg::MOVE_DOWN_RIGHT : gdt_pkg::MOVE_UP_RIGHT;
            end else begin
                direction = y_pos ? gdt_pkg::MOVE_DOWN_LEFT : gdt_pkg::MOVE_UP_LEFT;
            end
        end else if (abs_x > abs_y) begin
            direction = x_pos ? gdt_pkg::MOVE_RIGHT : gdt_pkg::MOVE_LEFT;
        end else begin
            direction = y_pos ? gdt_pkg::MOVE_DOWN : gdt_pkg::MOVE_UP;
        end
    end

endmodule

[rtl/gdt_track.sv]
// Gesture state: active flag, held button, saturating travel sums and the
// saturating tick counter, updated once per transaction, plus the result.
// Depends on gdt_pkg and gdt_classify.
module gdt_track #(
    parameter int unsigned ACC_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                advance,
    input  gdt_pkg::gdt_func_t                  func,
    input  logic        [gdt_pkg::BUTTON_W-1:0] button,
    input  logic signed [gdt_pkg::DELTA_W-1:0]  dx,
    input  logic signed [gdt_pkg::DELTA_W-1:0]  dy,
    input  logic        [gdt_pkg::THRESH_W-1:0] threshold,
    output gdt_pkg::gdt_result_t                result
);

    logic                               active_reg, active_next;
    logic        [gdt_pkg::BUTTON_W-1:0] button_reg, button_next;
    logic signed [ACC_BITS-1:0]         sum_x_reg, sum_x_next;
    logic signed [ACC_BITS-1:0]         sum_y_reg, sum_y_next;
    logic        [gdt_pkg::TICK_W-1:0]  tick_reg, tick_next;

    logic signed [ACC_BITS:0]   add_x;
    logic signed [ACC_BITS:0]   add_y;
    logic signed [ACC_BITS-1:0] sat_x;
    logic signed [ACC_BITS-1:0] sat_y;
    gdt_pkg::gdt_dir_t          class_dir;

    localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    assign add_x = {sum_x_reg[ACC_BITS-1], sum_x_reg}
                 + {{(ACC_BITS+1-gdt_pkg::DELTA_W){dx[gdt_pkg::DELTA_W-1]}}, dx};
    assign add_y = {sum_y_reg[ACC_BITS-1], sum_y_reg}
                 + {{(ACC_BITS+1-gdt_pkg::DELTA_W){dy[gdt_pkg::DELTA_W-1]}}, dy};

    always_comb begin
        if (add_x[ACC_BITS] != add_x[ACC_BITS-1]) begin
            sat_x = add_x[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end else begin
            sat_x = add_x[ACC_BITS-1:0];
        end
        if (add_y[ACC_BITS] != add_y[ACC_BITS-1]) begin
            sat_y = add_y[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end else begin
            sat_y = add_y[ACC_BITS-1:0];
        end
    end

    gdt_classify #(
        .ACC_BITS (ACC_BITS)
    ) u_classify (
        .sum_x     (sum_x_reg),
        .sum_y     (sum_y_reg),
        .threshold (threshold),
        .direction (class_dir)
    );

    always_comb begin
        active_next = active_reg;
        button_next = button_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        tick_next   = tick_reg;
        case (func)
            gdt_pkg::FN_TICK: begin
                if (tick_reg != gdt_pkg::TICK_MAX) begin
                    tick_next = tick_reg + 1'b1;
                end
            end
            gdt_pkg::FN_START: begin
                active_next = 1'b1;
                button_next = button;
                sum_x_next  = '0;
                sum_y_next  = '0;
                tick_next   = '0;
            end
            gdt_pkg::FN_STOP: begin
                active_next = 1'b0;
                button_next = '0;
                sum_x_next  = '0;
                sum_y_next  = '0;
                tick_next   = '0;
            end
            gdt_pkg::FN_MOTION: begin
                if (active_reg) begin
                    sum_x_next = sat_x;
                    sum_y_next = sat_y;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.active      = active_next;
        result.held_button = active_next ? button_next : '0;
        if ((func == gdt_pkg::FN_RESOLVE) && active_reg) begin
            result.direction = class_dir;
            result.elapsed   = tick_reg;
        end else begin
            result.direction = gdt_pkg::MOVE_NONE;
            result.elapsed   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            button_reg <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            tick_reg   <= '0;
        end else if (advance) begin
            active_reg <= active_next;
            button_reg <= button_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            tick_reg   <= tick_next;
        end
    end

endmodule

[rtl/gesture_direction_tracker_core.sv]
// Gesture direction tracker, top level. An accepted input is held in the input register,
// then loaded into the result register; one result per cycle while m_tready stays high.
// The input register feeds the state update and classifier, which load the result
// register; both stages advance together whenever the result side can take data.
// Reset clears the gesture state and both stages and sets the threshold to 100.
// Depends on gdt_pkg and gdt_track.
module gesture_direction_tracker_core #(
    parameter int unsigned ACC_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [47:0]                   s_tdata,   // button[9:0], dx[25:10], dy[41:26]
    input  logic [gdt_pkg::FUNC_W-1:0]    s_tuser,   // func[2:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,   // direction[3:0], active[4],
                                                     // held_button[14:5], elapsed[46:15]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gdt_pkg::THRESH_W-1:0]  cfg_data
);

    logic                                in_valid_reg;
    gdt_pkg::gdt_func_t                  func_reg;
    logic        [gdt_pkg::BUTTON_W-1:0] button_reg;
    logic signed [gdt_pkg::DELTA_W-1:0]  dx_reg;
    logic signed [gdt_pkg::DELTA_W-1:0]  dy_reg;
    logic        [gdt_pkg::THRESH_W-1:0] threshold_reg;
    logic                                out_valid_reg;
    gdt_pkg::gdt_result_t                result_reg, result_next;
    logic                                advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, result_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            threshold_reg <= gdt_pkg::THRESH_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                threshold_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg   <= gdt_pkg::gdt_func_t'(s_tuser);
            button_reg <= s_tdata[9:0];
            dx_reg     <= s_tdata[25:10];
            dy_reg     <= s_tdata[41:26];
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    gdt_track #(
        .ACC_BITS (ACC_BITS)
    ) u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .func      (func_reg),
        .button    (button_reg),
        .dx        (dx_reg),
        .dy        (dy_reg),
        .threshold (threshold_reg),
        .result    (result_next)
    );

    // A result with a direction always belongs to an active gesture.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (result_reg.direction != gdt_pkg::MOVE_NONE) |-> result_reg.active)
        else $error("direction reported for an inactive gesture");

    // An inactive gesture reports neither a button nor an elapsed count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !result_reg.active |->
            (result_reg.held_button == '0) && (result_reg.elapsed == '0))
        else $error("inactive result carries button or elapsed count");

    // A held input item is not overwritten while the result side stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(func_reg) && $stable(dx_reg))
        else $error("input stage overwritten during stall");

    // Reset empties both stages.
    assert property (@(posedge aclk) !aresetn |=> !in_valid_reg && !out_valid_reg)
        else $error("pipeline not empty after reset");

endmodule
